>>> design/jbe_pkg.sv
// Package for the job barrier: sizes, item codes and the request and response word types.
// Used by jbe_core and job_barrier_epoch. Depends on nothing else.
package jbe_pkg;

   localparam int MAX_JOBS   = 16;
   localparam int EPOCH_BITS = 16;
   localparam int ID_BITS    = 4;
   localparam int SLOT_COUNT = 1 << ID_BITS;
   localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_STEP   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PRESENT  = 2'd1,
      STATUS_ABSENT   = 2'd2
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [ID_BITS-1:0]   job_id;
   } req_word_type;

   typedef struct packed {
      logic        inhibited;
      logic        released;
      logic [15:0] epoch;
      status_type  status;
   } rsp_word_type;

endpackage

>>> design/jbe_core.sv
// Barrier state (slot and arrived bits, member and remaining counts, epoch) and the
// per-word update. Takes types and sizes from jbe_pkg.
module jbe_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  jbe_pkg::req_word_type word,
   output jbe_pkg::rsp_word_type result
);
   import jbe_pkg::*;

   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [SLOT_COUNT-1:0] arrived_ff, arrived_in;
   logic [COUNT_W-1:0]    member_ff, member_in;
   logic [COUNT_W-1:0]    remain_ff, remain_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;

   logic                  usable;
   logic                  present;
   logic                  arr;
   logic [COUNT_W-1:0]    rem_dec;
   logic [COUNT_W-1:0]    mem_dec;
   logic                  release_now;
   status_type            status;

   assign usable  = ({1'b0, word.job_id} < (ID_BITS + 1)'(MAX_JOBS))
                    || (MAX_JOBS >= SLOT_COUNT);
   assign present = usable && valid_ff[word.job_id];
   assign arr     = arrived_ff[word.job_id];
   assign rem_dec = (remain_ff != '0) ? remain_ff - COUNT_W'(1) : remain_ff;
   assign mem_dec = (member_ff != '0) ? member_ff - COUNT_W'(1) : member_ff;

   always_comb begin
      valid_in    = valid_ff;
      arrived_in  = arrived_ff;
      member_in   = member_ff;
      remain_in   = remain_ff;
      epoch_in    = epoch_ff;
      status      = STATUS_OK;
      release_now = 1'b0;
      case (word.kind)
         KIND_ADD: begin
            if (!usable) begin
               status = STATUS_ABSENT;
            end else if (present) begin
               status = STATUS_PRESENT;
            end else begin
               valid_in[word.job_id]   = 1'b1;
               arrived_in[word.job_id] = 1'b0;
               member_in = member_ff + COUNT_W'(1);
               remain_in = remain_ff + COUNT_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (!present) begin
               status = STATUS_ABSENT;
            end else begin
               remain_in = arr ? remain_ff : rem_dec;
               valid_in[word.job_id]   = 1'b0;
               arrived_in[word.job_id] = 1'b0;
               member_in = mem_dec;
               if (mem_dec == '0) begin
                  remain_in = '0;
               end else if (remain_in == '0) begin
                  release_now = 1'b1;
               end
            end
         end
         KIND_STEP: begin
            if (!present) begin
               status = STATUS_ABSENT;
            end else if (!arr) begin
               arrived_in[word.job_id] = 1'b1;
               remain_in = rem_dec;
               if (rem_dec == '0) begin
                  release_now = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      // open the next epoch
      if (release_now) begin
         arrived_in = '0;
         remain_in  = member_in;
         epoch_in   = epoch_ff + EPOCH_BITS'(1);
      end
   end

   assign result.inhibited = usable && valid_in[word.job_id] && arrived_in[word.job_id];
   assign result.released  = release_now;
   assign result.epoch     = 16'(epoch_in);
   assign result.status    = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         arrived_ff <= '0;
         member_ff  <= '0;
         remain_ff  <= '0;
         epoch_ff   <= '0;
      end else if (fire) begin
         valid_ff   <= valid_in;
         arrived_ff <= arrived_in;
         member_ff  <= member_in;
         remain_ff  <= remain_in;
         epoch_ff   <= epoch_in;
      end
   end

endmodule

>>> design/job_barrier_epoch.sv
// Top level of the job barrier: request register, barrier core, response register.
// Depends on jbe_pkg and jbe_core.
//
//   port group   dir   handshake              word
//   req_         in    req_valid/req_ready    req_word_type (kind, job_id)
//   rsp_         out   rsp_valid/rsp_ready    rsp_word_type (inhibited, released, epoch, status)
//
// A word passes from the request register to the response register, and one word is taken
// per cycle while the response is not stalled.
// The barrier state updates in that single pass, as the word moves to the response register.
// A stalled response holds the request register; a new word is taken whenever it empties.
// Synchronous reset clears all barrier state: no members, epoch zero.
module job_barrier_epoch (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jbe_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jbe_pkg::rsp_word_type rsp_data
);
   import jbe_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type core_result;
   logic         advance;
   logic         req_accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   jbe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .word   (in_word_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         rsp_word_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed word did not reach the response register");

   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("pending request word lost while stalled");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.released |-> !rsp_data.inhibited)
      else $error("job inhibited right after a release");

   a_error_no_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> !rsp_data.released)
      else $error("rejected word released the barrier");

endmodule
